// ----- src/vpp_pkg.sv -----
// ----------------------------------------------------------------------------
// vpp_pkg: shared types and constants for the vertex projection block
// Payload structs, register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vpp_pkg;

  // fixed field widths
  localparam int unsigned DIR_W   = 20;
  localparam int unsigned VERT_W  = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned CFG_W   = 60;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_AXIS_DIR    = 3'd0,
    CFG_Y_AXIS_DIR    = 3'd1,
    CFG_Z_AXIS_DIR    = 3'd2,
    CFG_WORLD_OFFSET  = 3'd3,
    CFG_CAMERA_HEIGHT = 3'd4,
    CFG_FOCAL_LENGTH  = 3'd5,
    CFG_ORTHO_MODE    = 3'd6,
    CFG_CANVAS_CENTER = 3'd7
  } cfg_idx_e;

  // one input vertex
  typedef struct packed {
    logic signed [VERT_W-1:0] vert_x;
    logic signed [VERT_W-1:0] vert_y;
    logic signed [VERT_W-1:0] vert_z;
    logic                     last_vertex;
  } vtx_t;

  // one projected result
  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic signed [DEPTH_W-1:0] depth;
    logic                      visible;
    logic                      last_pixel;
  } pix_t;

endpackage

`default_nettype wire

// ----- src/vertex_perspective_projection.sv -----
// ----------------------------------------------------------------------------
// vertex_perspective_projection
// Rotates a vertex by the direction matrix, offsets it, and projects it to
// screen pixels (orthographic rounding or perspective divide by depth).
// ----------------------------------------------------------------------------
//   channel   signals                              dir   moves
//   vertex    in_valid_i / in_stall_o / in_data_i  in    vtx_t
//   pixel     out_valid_o / out_stall_i / out_data_o out pix_t
//   config    cfg_we_i / cfg_idx_i / cfg_data_i    in    register write
//
// One vertex is taken per cycle unless a stalled output holds the pipeline.
// The path has four arithmetic stages, an 18-stage restoring divider (one
// quotient bit per stage) and the output register. The divider depth sets most of the latency.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_perspective_projection
  import vpp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire vtx_t                 in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pix_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // internal widths
  localparam int unsigned PW = VERT_W + DIR_W;         // one product
  localparam int unsigned WW = PW + 3;                 // world x/y/z
  localparam int unsigned DW = DEPTH_W + FRAC_BITS + 2; // exact depth
  localparam int unsigned MW = WW + 17;                // world * focal
  localparam int unsigned QW = COORD_W + 2;            // clamped quotient
  localparam int unsigned RW = MW + 2 + QW;            // divider remainder
  localparam int unsigned FW = WW + 2;                 // final sum
  localparam int unsigned NS = 4;                      // stages before divider

  // configuration registers
  logic [CFG_W-1:0]          xdir_q, ydir_q;
  logic [2*DIR_W-1:0]        zdir_q;
  logic [31:0]               woff_q;
  logic signed [DEPTH_W-1:0] cam_q;
  logic [15:0]               focal_q;
  logic                      ortho_q;
  logic [31:0]               center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xdir_q   <= CFG_W'(1024);
      ydir_q   <= CFG_W'(1073741824);
      zdir_q   <= (2*DIR_W)'(1073741824);
      woff_q   <= '0;
      cam_q    <= DEPTH_W'(1000);
      focal_q  <= 16'd1024;
      ortho_q  <= 1'b1;
      center_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_AXIS_DIR:    xdir_q   <= cfg_data_i;
        CFG_Y_AXIS_DIR:    ydir_q   <= cfg_data_i;
        CFG_Z_AXIS_DIR:    zdir_q   <= cfg_data_i[2*DIR_W-1:0];
        CFG_WORLD_OFFSET:  woff_q   <= cfg_data_i[31:0];
        CFG_CAMERA_HEIGHT: cam_q    <= cfg_data_i[DEPTH_W-1:0];
        CFG_FOCAL_LENGTH:  focal_q  <= cfg_data_i[15:0];
        CFG_ORTHO_MODE:    ortho_q  <= cfg_data_i[0];
        CFG_CANVAS_CENTER: center_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // matrix entries
  logic signed [DIR_W-1:0] dxx, dxy, dxz, dyx, dyy, dyz, dzy, dzz;
  assign dxx = xdir_q[DIR_W-1:0];
  assign dxy = xdir_q[2*DIR_W-1:DIR_W];
  assign dxz = xdir_q[3*DIR_W-1:2*DIR_W];
  assign dyx = ydir_q[DIR_W-1:0];
  assign dyy = ydir_q[2*DIR_W-1:DIR_W];
  assign dyz = ydir_q[3*DIR_W-1:2*DIR_W];
  assign dzy = zdir_q[DIR_W-1:0];
  assign dzz = zdir_q[2*DIR_W-1:DIR_W];

  // global advance: the pipe moves unless a finished result is held
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [NS-1:0] v_q;

  // stage 1: the eight matrix products
  logic signed [PW-1:0] p_q [8];
  logic                 l1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= in_data_i.vert_x * dxx;
      p_q[1] <= in_data_i.vert_y * dyx;
      p_q[2] <= in_data_i.vert_x * dxy;
      p_q[3] <= in_data_i.vert_y * dyy;
      p_q[4] <= in_data_i.vert_z * dzy;
      p_q[5] <= in_data_i.vert_x * dxz;
      p_q[6] <= in_data_i.vert_y * dyz;
      p_q[7] <= in_data_i.vert_z * dzz;
      l1_q   <= in_data_i.last_vertex;
    end
  end

  // stage 2: world coordinates and exact depth
  logic signed [WW-1:0] wx_q, wy_q;
  logic signed [DW-1:0] dep_q;
  logic signed [WW-1:0] wz_d;
  logic                 l2_q;

  assign wz_d = WW'(p_q[5]) + WW'(p_q[6]) + WW'(p_q[7]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q  <= WW'(p_q[0]) + WW'(p_q[1])
             + (WW'($signed(woff_q[15:0])) <<< FRAC_BITS);
      wy_q  <= WW'(p_q[2]) + WW'(p_q[3]) + WW'(p_q[4])
             + (WW'($signed(woff_q[31:16])) <<< FRAC_BITS);
      dep_q <= (DW'(cam_q) <<< FRAC_BITS) - DW'(wz_d);
      l2_q  <= l1_q;
    end
  end

  // stage 3: near test, ortho rounding, focal multiply, depth saturation
  logic signed [DW+3:0]    dep10, one_w;
  logic                    near_d;
  logic [WW-1:0]           magx, magy, rmx, rmy;
  logic signed [WW-1:0]    rx_d, ry_d;
  logic signed [DEPTH_W-1:0] dsat_d;
  logic signed [DW-1:0]    dmax, dmin;

  assign dep10  = (DW+4)'(dep_q) * (DW+4)'(10);
  assign one_w  = (DW+4)'(1) <<< FRAC_BITS;
  assign near_d = !ortho_q && (dep10 <= one_w);
  assign magx   = wx_q[WW-1] ? WW'(-wx_q) : WW'(wx_q);
  assign magy   = wy_q[WW-1] ? WW'(-wy_q) : WW'(wy_q);
  assign rmx    = (magx + (WW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rmy    = (magy + (WW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rx_d   = wx_q[WW-1] ? -$signed(rmx) : $signed(rmx);
  assign ry_d   = wy_q[WW-1] ? -$signed(rmy) : $signed(rmy);
  assign dmax   = DW'($signed({1'b0, {(DEPTH_W-1){1'b1}}}));
  assign dmin   = -dmax - DW'(1);
  assign dsat_d = (dep_q > dmax) ? DEPTH_W'(dmax) :
                  (dep_q < dmin) ? DEPTH_W'(dmin) : DEPTH_W'(dep_q);

  typedef struct packed {
    logic signed [WW-1:0]      rx;
    logic signed [WW-1:0]      ry;
    logic signed [DEPTH_W-1:0] depth;
    logic                      vis;
    logic                      last;
    logic                      sx;
    logic                      sy;
    logic                      ovfx;
    logic                      ovfy;
  } side_t;

  logic signed [MW-1:0] mx_q, my_q;
  logic signed [DW-1:0] dep3_q;
  logic                 near3_q;
  side_t                s3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q       <= MW'(wx_q) * MW'($signed({1'b0, focal_q}));
      my_q       <= MW'(wy_q) * MW'($signed({1'b0, focal_q}));
      dep3_q     <= dep_q;
      near3_q    <= near_d;
      s3_q.rx    <= rx_d;
      s3_q.ry    <= ry_d;
      s3_q.depth <= dsat_d;
      s3_q.vis   <= !near_d;
      s3_q.last  <= l2_q;
      s3_q.sx    <= 1'b0;
      s3_q.sy    <= 1'b0;
      s3_q.ovfx  <= 1'b0;
      s3_q.ovfy  <= 1'b0;
    end
  end

  // stage 4: divider operands, n = 2|m| + d (zero for a near vertex), divisor 2d, overflow test
  logic [MW-1:0] mmx, mmy;
  logic [RW-1:0] nx_d, ny_d, dd_d;
  side_t         s4_d;

  assign mmx  = mx_q[MW-1] ? MW'(-mx_q) : MW'(mx_q);
  assign mmy  = my_q[MW-1] ? MW'(-my_q) : MW'(my_q);
  assign dd_d = RW'($unsigned(dep3_q)) << 1;
  assign nx_d = near3_q ? '0 : (RW'(mmx) << 1) + RW'($unsigned(dep3_q));
  assign ny_d = near3_q ? '0 : (RW'(mmy) << 1) + RW'($unsigned(dep3_q));

  always_comb begin
    s4_d      = s3_q;
    s4_d.sx   = mx_q[MW-1];
    s4_d.sy   = my_q[MW-1];
    s4_d.ovfx = nx_d >= (dd_d << QW);
    s4_d.ovfy = ny_d >= (dd_d << QW);
  end

  logic [RW-1:0] rx_q [QW+1];
  logic [RW-1:0] ry_q [QW+1];
  logic [RW-1:0] dv_q [QW+1];
  logic [QW-1:0] qx_q [QW+1];
  logic [QW-1:0] qy_q [QW+1];
  side_t         sd_q [QW+1];
  logic [QW-1:0] dvv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q[0] <= nx_d;
      ry_q[0] <= ny_d;
      dv_q[0] <= dd_d;
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      sd_q[0] <= s4_d;
    end
  end

  // divider: one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned B = QW - 1 - k;
    logic [RW-1:0] tx, ty;
    logic          bx, by;
    assign tx = dv_q[k] << B;
    assign ty = dv_q[k] << B;
    assign bx = rx_q[k] >= tx;
    assign by = ry_q[k] >= ty;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx_q[k+1] <= bx ? rx_q[k] - tx : rx_q[k];
        ry_q[k+1] <= by ? ry_q[k] - ty : ry_q[k];
        qx_q[k+1] <= {qx_q[k][QW-2:0], bx};
        qy_q[k+1] <= {qy_q[k][QW-2:0], by};
        dv_q[k+1] <= dv_q[k];
        sd_q[k+1] <= sd_q[k];
      end
    end
  end

  // final: sign, mode select, canvas center, saturation
  // a near vertex has a zero quotient whatever the divider holds
  side_t                sf;
  logic [QW-1:0]        qcx, qcy;
  logic signed [FW-1:0] ax, ay, sx_d, sy_d, cmax, cmin;

  assign sf   = sd_q[QW];
  assign qcx  = !sf.vis ? '0 : sf.ovfx ? '1 : qx_q[QW];
  assign qcy  = !sf.vis ? '0 : sf.ovfy ? '1 : qy_q[QW];
  assign ax   = ortho_q ? FW'(sf.rx) :
                sf.sx ? -FW'($signed({1'b0, qcx})) : FW'($signed({1'b0, qcx}));
  assign ay   = ortho_q ? FW'(sf.ry) :
                sf.sy ? -FW'($signed({1'b0, qcy})) : FW'($signed({1'b0, qcy}));
  assign sx_d = ax + FW'($signed({1'b0, center_q[15:0]}));
  assign sy_d = ay + FW'($signed({1'b0, center_q[31:16]}));
  assign cmax = FW'($signed({1'b0, {(COORD_W-1){1'b1}}}));
  assign cmin = -cmax - FW'(1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.pixel_x    <= (sx_d > cmax) ? COORD_W'(cmax) :
                               (sx_d < cmin) ? COORD_W'(cmin) : COORD_W'(sx_d);
      out_data_o.pixel_y    <= (sy_d > cmax) ? COORD_W'(cmax) :
                               (sy_d < cmin) ? COORD_W'(cmin) : COORD_W'(sy_d);
      out_data_o.depth      <= sf.depth;
      out_data_o.visible    <= sf.vis;
      out_data_o.last_pixel <= sf.last;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      dvv_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[NS-2:0], in_valid_i};
      dvv_q       <= {dvv_q[QW-2:0], v_q[NS-1]};
      out_valid_o <= dvv_q[QW-1];
    end
  end

  // checks
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[QW-1] && adv |=> out_valid_o)
    else $error("divider output lost on its way to the output register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dvv_q))
    else $error("pipeline moved while the output was stalled");

  a_ortho_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ortho_q && $stable(ortho_q) |-> out_data_o.visible)
    else $error("orthographic result marked invisible");

endmodule

`default_nettype wire
